### src/clsu_pkg.sv
// Shared types and constants for the command line splitter.
package clsu_pkg;

   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OPEN_QUOTE = 1'b1;

   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_QUOTED  = 2'd1,
      MODE_BARE    = 2'd2,
      MODE_SPAN    = 2'd3
   } mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [7:0] data;
      logic       has_data;
      logic       arg_done;
      logic       cmd_done;
      logic       status;
   } rsp_type;

endpackage

### src/command_line_splitter_unit.sv
// Top level of the command line splitter: input register, tokenizer step, result register.
//
// Takes one command line byte (or the end marker) per beat and gives at most one
// result beat per item: an argument byte, an argument-done mark, or the
// end-of-command beat with its status. One item is accepted every cycle while
// results are drained; an accepted item moves from the input register to the result
// register once the result slot is free. The rate is set by the mode update between the input
// register and the result register. Items that give no result (separators between
// arguments, a leading quote) pass without taking a result slot.
module command_line_splitter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  clsu_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output clsu_pkg::rsp_type rsp_item
);
   import clsu_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff;
   mode_type mode_ff, mode_in;
   logic     quote_dbl_ff, quote_dbl_in;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_item_ff;

   logic    emit;
   rsp_type step_rsp;
   logic    advance;

   clsu_decode u_decode (
      .mode           (mode_ff),
      .quote_dbl      (quote_dbl_ff),
      .item           (in_item_ff),
      .mode_next      (mode_in),
      .quote_dbl_next (quote_dbl_in),
      .emit           (emit),
      .rsp            (step_rsp)
   );

   // an item leaves the input register if it needs no slot or the slot frees this cycle
   assign advance   = in_valid_ff && (!emit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) in_valid_in = req_valid;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_BETWEEN;
         quote_dbl_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff      <= mode_in;
            quote_dbl_ff <= quote_dbl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_item_ff <= req_item;
      if (advance && emit) out_item_ff <= step_rsp;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

### src/clsu_decode.sv
// One step of the tokenizer: next mode and the result beat for one item.
module clsu_decode (
   input  clsu_pkg::mode_type mode,
   input  logic               quote_dbl,
   input  clsu_pkg::req_type  item,
   output clsu_pkg::mode_type mode_next,
   output logic               quote_dbl_next,
   output logic               emit,
   output clsu_pkg::rsp_type  rsp
);
   import clsu_pkg::*;

   logic is_sep;
   logic is_quote;
   logic closes;
   logic is_dq;

   assign is_sep   = (item.ch == CHAR_SPACE) || (item.ch == CHAR_TAB);
   assign is_dq    = (item.ch == CHAR_DQUOTE);
   assign is_quote = is_dq || (item.ch == CHAR_SQUOTE);
   assign closes   = (item.ch == (quote_dbl ? CHAR_DQUOTE : CHAR_SQUOTE));

   // next state
   always_comb begin
      mode_next      = mode;
      quote_dbl_next = quote_dbl;
      if (item.kind == KIND_END) begin
         mode_next      = MODE_BETWEEN;
         quote_dbl_next = 1'b0;
      end else begin
         unique case (mode)
            MODE_BETWEEN: begin
               if (is_quote) begin
                  mode_next      = MODE_QUOTED;
                  quote_dbl_next = is_dq;
               end else if (!is_sep) begin
                  mode_next = MODE_BARE;
               end
            end
            MODE_QUOTED: begin
               if (closes) mode_next = MODE_BETWEEN;
            end
            MODE_BARE: begin
               if (is_sep) begin
                  mode_next = MODE_BETWEEN;
               end else if (is_quote) begin
                  mode_next      = MODE_SPAN;
                  quote_dbl_next = is_dq;
               end
            end
            MODE_SPAN: begin
               if (closes) mode_next = MODE_BARE;
            end
            default: mode_next = MODE_BETWEEN;
         endcase
      end
   end

   // result beat
   always_comb begin
      emit         = 1'b1;
      rsp.data     = item.ch;
      rsp.has_data = 1'b1;
      rsp.arg_done = 1'b0;
      rsp.cmd_done = 1'b0;
      rsp.status   = STATUS_OK;
      if (item.kind == KIND_END) begin
         rsp.data     = 8'h00;
         rsp.has_data = 1'b0;
         rsp.cmd_done = 1'b1;
         rsp.arg_done = (mode == MODE_BARE);
         rsp.status   = ((mode == MODE_QUOTED) || (mode == MODE_SPAN)) ?
                        STATUS_OPEN_QUOTE : STATUS_OK;
      end else begin
         unique case (mode)
            MODE_BETWEEN: begin
               if (is_sep || is_quote) emit = 1'b0;
            end
            MODE_QUOTED: begin
               if (closes) begin
                  rsp.data     = 8'h00;
                  rsp.has_data = 1'b0;
                  rsp.arg_done = 1'b1;
               end
            end
            MODE_BARE: begin
               if (is_sep) begin
                  rsp.data     = 8'h00;
                  rsp.has_data = 1'b0;
                  rsp.arg_done = 1'b1;
               end
            end
            MODE_SPAN: ;
            default: emit = 1'b0;
         endcase
      end
   end

endmodule

### src/clsu_checker.sv
// Port-level checks for the command line splitter, bound to the top level.
module clsu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input clsu_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input clsu_pkg::rsp_type rsp_item
);
   import clsu_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result beat changed while stalled");

   // a byte beat carries no completion marks
   a_byte_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.has_data |->
         !rsp_item.arg_done && !rsp_item.cmd_done && rsp_item.status == STATUS_OK)
      else $error("byte beat carries completion marks");

   // open-quote status only on the end-of-command beat, which never completes an argument
   a_status_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_OPEN_QUOTE |->
         rsp_item.cmd_done && !rsp_item.arg_done)
      else $error("open-quote status outside end beat");

   // a beat without a byte has zero data and marks something
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.has_data |->
         rsp_item.data == 8'h00 && (rsp_item.arg_done || rsp_item.cmd_done))
      else $error("empty result beat");

   // a stalled input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_item))
      else $error("input beat changed while stalled");

endmodule

bind command_line_splitter_unit clsu_checker u_clsu_checker (.*);

### sim/testbench.sv
// Self-checking testbench for the command line splitter: random lines, stalls and a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import clsu_pkg::*;

   // Tracks the tokenizer state and holds the result beats still owed by the block.
   class split_tracker;
      mode_type mode;
      bit       quote_is_double;
      rsp_type  owed_beats[$];
      int       failures;
      int       reported;
      int       beats_matched;
      int       open_quote_ends;

      function new();
         mode = MODE_BETWEEN;
         quote_is_double = 1'b0;
         failures = 0;
         reported = 0;
         beats_matched = 0;
         open_quote_ends = 0;
      endfunction

      function bit is_sep(logic [7:0] c);
         return c == CHAR_SPACE || c == CHAR_TAB;
      endfunction

      function bit is_quote(logic [7:0] c);
         return c == CHAR_SQUOTE || c == CHAR_DQUOTE;
      endfunction

      function bit closes(logic [7:0] c);
         return c == (quote_is_double ? CHAR_DQUOTE : CHAR_SQUOTE);
      endfunction

      function int pending();
         return owed_beats.size();
      endfunction

      // Works out what one accepted line beat should give.
      function void note_line_beat(req_type item);
         rsp_type r;
         bit      gives;
         r = '0;
         r.status = STATUS_OK;
         gives = 1'b1;
         if (item.kind == KIND_END) begin
            r.cmd_done = 1'b1;
            case (mode)
               MODE_QUOTED, MODE_SPAN: begin
                  r.status = STATUS_OPEN_QUOTE;
                  open_quote_ends++;
               end
               MODE_BARE: r.arg_done = 1'b1;
               default: ;
            endcase
            mode = MODE_BETWEEN;
            quote_is_double = 1'b0;
         end else begin
            case (mode)
               MODE_BETWEEN: begin
                  if (is_sep(item.ch)) begin
                     gives = 1'b0;
                  end else if (is_quote(item.ch)) begin
                     quote_is_double = (item.ch == CHAR_DQUOTE);
                     mode = MODE_QUOTED;
                     gives = 1'b0;
                  end else begin
                     mode = MODE_BARE;
                     r.data = item.ch;
                     r.has_data = 1'b1;
                  end
               end
               MODE_QUOTED: begin
                  if (closes(item.ch)) begin
                     mode = MODE_BETWEEN;
                     r.arg_done = 1'b1;
                  end else begin
                     r.data = item.ch;
                     r.has_data = 1'b1;
                  end
               end
               MODE_BARE: begin
                  if (is_sep(item.ch)) begin
                     mode = MODE_BETWEEN;
                     r.arg_done = 1'b1;
                  end else begin
                     if (is_quote(item.ch)) begin
                        quote_is_double = (item.ch == CHAR_DQUOTE);
                        mode = MODE_SPAN;
                     end
                     r.data = item.ch;
                     r.has_data = 1'b1;
                  end
               end
               default: begin
                  if (closes(item.ch))
                     mode = MODE_BARE;
                  r.data = item.ch;
                  r.has_data = 1'b1;
               end
            endcase
         end
         if (gives)
            owed_beats = {owed_beats, r};
      endfunction

      function void check_arg_beat(rsp_type got);
         rsp_type want;
         if (owed_beats.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("unexpected result beat: data=%02h has=%0b arg=%0b cmd=%0b st=%0b",
                        got.data, got.has_data, got.arg_done, got.cmd_done, got.status);
            end
            return;
         end
         want = owed_beats.pop_front();
         beats_matched++;
         if (got.data !== want.data || got.has_data !== want.has_data ||
             got.arg_done !== want.arg_done || got.cmd_done !== want.cmd_done ||
             got.status !== want.status) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("mismatch on beat %0d: expected data=%02h has=%0b arg=%0b cmd=%0b st=%0b",
                        beats_matched, want.data, want.has_data, want.arg_done,
                        want.cmd_done, want.status);
               $display("                      got      data=%02h has=%0b arg=%0b cmd=%0b st=%0b",
                        got.data, got.has_data, got.arg_done, got.cmd_done, got.status);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   split_tracker tracker = new();
   bit quiet;
   int items_sent;
   int lines_sent;

   logic [8:0] opening [25] = '{
      {KIND_END,  8'hA5},
      {KIND_BYTE, 8'h00},
      {KIND_BYTE, 8'hFF},
      {KIND_BYTE, CHAR_TAB},
      {KIND_BYTE, CHAR_SQUOTE},
      {KIND_BYTE, CHAR_SPACE},
      {KIND_BYTE, CHAR_DQUOTE},
      {KIND_BYTE, CHAR_SQUOTE},
      {KIND_BYTE, CHAR_DQUOTE},
      {KIND_BYTE, CHAR_DQUOTE},
      {KIND_BYTE, 8'h61},
      {KIND_BYTE, CHAR_DQUOTE},
      {KIND_BYTE, CHAR_SPACE},
      {KIND_BYTE, CHAR_SQUOTE},
      {KIND_BYTE, CHAR_DQUOTE},
      {KIND_END,  8'hFF},
      {KIND_BYTE, CHAR_SQUOTE},
      {KIND_BYTE, 8'h78},
      {KIND_END,  8'h00},
      {KIND_BYTE, 8'h62},
      {KIND_BYTE, CHAR_SQUOTE},
      {KIND_END,  CHAR_SPACE},
      {KIND_BYTE, CHAR_SPACE},
      {KIND_BYTE, CHAR_TAB},
      {KIND_END,  8'h00}
   };

   command_line_splitter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic bit idle_now();
      return !quiet && ($urandom_range(99) < 15);
   endfunction

   always @(negedge clock) begin
      rsp_stall <= idle_now();
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         tracker.note_line_beat(req_item);
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_arg_beat(rsp_item);
   end

   function automatic logic [7:0] pick_special();
      case ($urandom_range(3))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_SQUOTE;
         default: return CHAR_DQUOTE;
      endcase
   endfunction

   function automatic logic [7:0] pick_sep();
      return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   function automatic logic [7:0] pick_quote();
      return $urandom_range(1) ? CHAR_SQUOTE : CHAR_DQUOTE;
   endfunction

   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_SQUOTE || c == CHAR_DQUOTE);
      return c;
   endfunction

   // Anything but the closing quote q, biased towards separators and quotes.
   function automatic logic [7:0] pick_inside(logic [7:0] q);
      logic [7:0] c;
      do begin
         c = $urandom_range(1) ? pick_special() : 8'($urandom_range(255));
      end while (c == q);
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic kind, input logic [7:0] ch);
      req_type item;
      item.kind = kind;
      item.ch = ch;
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      int   n_args;
      bit   broken;
      bit   last;
      bit   quoted;
      logic [7:0] q;
      if ($urandom_range(99) < 15) begin
         // noise: any bytes at all, quotes and separators frequent
         repeat ($urandom_range(1, 16))
            send_beat(KIND_BYTE, $urandom_range(1) ? pick_special() : 8'($urandom_range(255)));
      end else begin
         n_args = $urandom_range(0, 5);
         broken = ($urandom_range(99) < 10);
         repeat ($urandom_range(0, 2))
            send_beat(KIND_BYTE, pick_sep());
         for (int a = 0; a < n_args; a++) begin
            last = (a == n_args - 1);
            q = pick_quote();
            quoted = ($urandom_range(99) < 40);
            if (quoted) begin
               send_beat(KIND_BYTE, q);
               repeat ($urandom_range(0, 6))
                  send_beat(KIND_BYTE, pick_inside(q));
               if (!(broken && last))
                  send_beat(KIND_BYTE, q);
            end else begin
               repeat ($urandom_range(1, 6))
                  send_beat(KIND_BYTE, pick_plain());
               if ($urandom_range(99) < 30) begin
                  send_beat(KIND_BYTE, q);
                  repeat ($urandom_range(0, 4))
                     send_beat(KIND_BYTE, pick_inside(q));
                  if (!(broken && last)) begin
                     send_beat(KIND_BYTE, q);
                     repeat ($urandom_range(0, 3))
                        send_beat(KIND_BYTE, pick_plain());
                  end
               end
            end
            // a quoted argument may be followed directly by the next one
            if (!last || $urandom_range(1))
               repeat (quoted ? $urandom_range(0, 2) : $urandom_range(1, 2))
                  send_beat(KIND_BYTE, pick_sep());
         end
      end
      send_beat(KIND_END, 8'($urandom_range(255)));
      lines_sent++;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      quiet = 1'b0;
      items_sent = 0;
      lines_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening[i])
         send_beat(opening[i][8], opening[i][7:0]);

      while (items_sent < 1840) begin
         if (lines_sent == 30) begin
            // hold the sender off until the block has drained
            req_valid <= 1'b0;
            while (tracker.pending() != 0)
               @(negedge clock);
         end
         quiet = (lines_sent >= 60 && lines_sent < 110);
         send_line();
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (tracker.pending() != 0) begin
         tracker.failures += tracker.pending();
         $display("%0d result beats never arrived", tracker.pending());
      end
      $display("run covered %0d input beats in %0d command lines, %0d result beats checked",
               items_sent, lines_sent, tracker.beats_matched);
      $display("%0d lines ended with an open quote, %0d failures", tracker.open_quote_ends,
               tracker.failures);
      if (tracker.failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout waiting for the block");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
